/* rtl/core/sliding_window_rate_limiter_top_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the sliding window rate limiter
// Concurrent checks compiled in simulation and empty for synthesis
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_RATE_LIMITER_TOP_MACROS_SVH
`define SLIDING_WINDOW_RATE_LIMITER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled in reset
`define SWRL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SWRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SWRL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define SWRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/core/swrl_pkg.sv */
// ---------------------------------------------------------------------------
// swrl_pkg
// Shared constants and types of the sliding window rate limiter
// ---------------------------------------------------------------------------
`default_nettype none

package swrl_pkg;

    // default sizes
    localparam int DEF_MAX_QUOTA = 64;
    localparam int DEF_TIME_BITS = 48;

    // register widths
    localparam int WINDOW_W   = 32;
    localparam int QUOTA_W    = 7;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LENGTH = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_QUOTA_IN_USE  = 1'd1;

    // register reset values
    localparam logic [WINDOW_W-1:0] RESET_WINDOW = 32'd1000;
    localparam logic [QUOTA_W-1:0]  RESET_QUOTA  = 7'd64;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [WINDOW_W-1:0] window_length;
        logic [QUOTA_W-1:0]  quota_in_use;
    } swrl_cfg_t;

endpackage

`default_nettype wire

/* rtl/core/sliding_window_rate_limiter_top.sv */
// ---------------------------------------------------------------------------
// sliding_window_rate_limiter_top
// Sliding window rate limiter with a ring of permitted-time slots
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel carries one request word per event (now_time in s_tdata).
//   m_ channel returns exactly one word per request (permitted_time).
//   cfg_wr_en/cfg_addr/cfg_wdata write window_length (0) and quota_in_use (1);
//   write only while no request is in flight, which the block does not enforce.
// Path: an accepted request loads the compute stage (b_ regs and registered
//   slot read), then the output register that drives m_tvalid once it is free.
// Throughput: one request per cycle unless clearing or stalled, one slot read
//   and one slot write of the slot memory each cycle; a request that reuses the
//   slot written in the same cycle gets the value forwarded from the compute stage.
// Reset: registers return to window 1000, quota 64, pointer to slot zero;
//   the slot memory is then cleared one entry a cycle over every entry,
//   with s_tready low meanwhile.
// Stall: with m_tready low the output word holds, one more request can sit
//   in the compute stage, and s_tready drops once both are full.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_rate_limiter_top_macros.svh"

module sliding_window_rate_limiter_top #(
    parameter int MAX_QUOTA = swrl_pkg::DEF_MAX_QUOTA,
    parameter int TIME_BITS = swrl_pkg::DEF_TIME_BITS,
    parameter int DATA_W    = ((TIME_BITS + 7) / 8) * 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // request channel
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [DATA_W-1:0]                 s_tdata,   // now_time
    // result channel
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [DATA_W-1:0]                 m_tdata,   // permitted_time
    // register write port
    input  wire logic                              cfg_wr_en,
    input  wire logic [swrl_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [swrl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int IDX_W = (MAX_QUOTA > 1) ? $clog2(MAX_QUOTA) : 1;

    swrl_pkg::swrl_cfg_t  cfg_reg;

    logic                 s_fire;
    logic                 b_adv;
    logic                 clr_busy;
    logic [IDX_W-1:0]     cur_idx;
    logic [TIME_BITS-1:0] rd_data;
    logic [TIME_BITS-1:0] stamp;
    logic [TIME_BITS-1:0] b_permitted;

    logic                 b_valid_reg;
    logic [TIME_BITS-1:0] b_now_reg;
    logic [IDX_W-1:0]     b_idx_reg;
    logic                 fwd_hit_reg;
    logic [TIME_BITS-1:0] fwd_val_reg;
    logic                 out_valid_reg;
    logic [TIME_BITS-1:0] out_data_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_length <= swrl_pkg::RESET_WINDOW;
            cfg_reg.quota_in_use  <= swrl_pkg::RESET_QUOTA;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                swrl_pkg::REG_WINDOW_LENGTH: begin
                    cfg_reg.window_length <= cfg_wdata[swrl_pkg::WINDOW_W-1:0];
                end
                swrl_pkg::REG_QUOTA_IN_USE: begin
                    cfg_reg.quota_in_use <= cfg_wdata[swrl_pkg::QUOTA_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // handshake
    assign b_adv    = !out_valid_reg || m_tready;
    assign s_tready = !clr_busy && (!b_valid_reg || b_adv);
    assign s_fire   = s_tvalid && s_tready;

    swrl_slot_ptr #(
        .MAX_QUOTA (MAX_QUOTA),
        .IDX_W     (IDX_W)
    ) u_ptr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .advance (s_fire),
        .cur_idx (cur_idx)
    );

    swrl_slot_ram #(
        .MAX_QUOTA (MAX_QUOTA),
        .TIME_BITS (TIME_BITS),
        .IDX_W     (IDX_W)
    ) u_ram (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (s_fire),
        .rd_addr  (cur_idx),
        .rd_data  (rd_data),
        .wr_en    (b_valid_reg && b_adv),
        .wr_addr  (b_idx_reg),
        .wr_data  (b_permitted),
        .clr_busy (clr_busy)
    );

    // slot value, forwarded when the previous request wrote the same slot
    assign stamp = fwd_hit_reg ? fwd_val_reg : rd_data;

    swrl_time_calc #(
        .TIME_BITS (TIME_BITS)
    ) u_calc (
        .stamp          (stamp),
        .window_length  (cfg_reg.window_length),
        .now_time       (b_now_reg),
        .permitted_time (b_permitted)
    );

    // compute stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end else if (s_fire) begin
            b_valid_reg <= 1'b1;
            fwd_hit_reg <= b_valid_reg && (b_idx_reg == cur_idx);
        end else if (b_adv) begin
            b_valid_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
    end

    // compute stage payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            b_now_reg   <= s_tdata[TIME_BITS-1:0];
            b_idx_reg   <= cur_idx;
            fwd_val_reg <= b_permitted;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (b_adv) begin
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_adv && b_valid_reg) begin
            out_data_reg <= b_permitted;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_W'(out_data_reg);

    // checks
    `SWRL_ASSERT_IMPLIES(a_no_accept_in_clear, aclk, aresetn,
        clr_busy, !s_tready, "request accepted during slot clearing")
    `SWRL_ASSERT_NEXT(a_fwd_on_same_slot, aclk, aresetn,
        s_fire && b_valid_reg && (b_idx_reg == cur_idx), fwd_hit_reg,
        "back-to-back reuse of a slot not forwarded")
    `SWRL_ASSERT_IMPLIES(a_fwd_needs_item, aclk, aresetn,
        fwd_hit_reg, b_valid_reg, "forward flag set with empty compute stage")
    `SWRL_ASSERT_NEXT(a_stage_holds, aclk, aresetn,
        b_valid_reg && !b_adv, b_valid_reg && $stable(b_idx_reg),
        "compute stage lost its request while stalled")

endmodule

`default_nettype wire

/* rtl/core/swrl_slot_ram.sv */
// ---------------------------------------------------------------------------
// swrl_slot_ram
// Slot stamp memory with registered read and a clearing pass after reset
// ---------------------------------------------------------------------------
`default_nettype none

module swrl_slot_ram #(
    parameter int MAX_QUOTA = swrl_pkg::DEF_MAX_QUOTA,
    parameter int TIME_BITS = swrl_pkg::DEF_TIME_BITS,
    parameter int IDX_W     = (MAX_QUOTA > 1) ? $clog2(MAX_QUOTA) : 1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 rd_en,
    input  wire logic [IDX_W-1:0]     rd_addr,
    output logic      [TIME_BITS-1:0] rd_data,
    input  wire logic                 wr_en,
    input  wire logic [IDX_W-1:0]     wr_addr,
    input  wire logic [TIME_BITS-1:0] wr_data,
    output logic                      clr_busy
);

    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(MAX_QUOTA - 1);

    logic [TIME_BITS-1:0] mem [MAX_QUOTA];
    logic [TIME_BITS-1:0] rd_data_reg;
    logic                 clearing_reg;
    logic                 clearing_next;
    logic [IDX_W-1:0]     clr_addr_reg;
    logic [IDX_W-1:0]     clr_addr_next;

    // clearing sweep, one entry per cycle
    always_comb begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR) begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // single write port, shared by the sweep and the datapath
    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clearing_reg;

endmodule

`default_nettype wire

/* rtl/core/swrl_slot_ptr.sv */
// ---------------------------------------------------------------------------
// swrl_slot_ptr
// Oldest slot pointer, wrapped at the effective quota
// ---------------------------------------------------------------------------
`default_nettype none

module swrl_slot_ptr #(
    parameter int MAX_QUOTA = swrl_pkg::DEF_MAX_QUOTA,
    parameter int IDX_W     = (MAX_QUOTA > 1) ? $clog2(MAX_QUOTA) : 1
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire swrl_pkg::swrl_cfg_t    cfg,
    input  wire logic                   advance,
    output logic      [IDX_W-1:0]       cur_idx
);

    localparam int QW = $clog2(MAX_QUOTA + 1);
    localparam int CW = (QW > swrl_pkg::QUOTA_W) ? QW : swrl_pkg::QUOTA_W;
    localparam logic [CW-1:0] MAX_Q = CW'(MAX_QUOTA);

    logic [IDX_W-1:0] oldest_reg;
    logic [IDX_W-1:0] oldest_next;
    logic [CW-1:0]    quota_ext;
    logic [CW-1:0]    eff_quota;
    logic [CW-1:0]    inc_ext;

    // quota of zero counts as one, above the store size as the store size
    always_comb begin
        quota_ext = CW'(cfg.quota_in_use);
        if (quota_ext == '0) begin
            eff_quota = CW'(1);
        end else if (quota_ext > MAX_Q) begin
            eff_quota = MAX_Q;
        end else begin
            eff_quota = quota_ext;
        end
    end

    // current slot and the one after it
    always_comb begin
        if (CW'(oldest_reg) >= eff_quota) begin
            cur_idx = '0;
        end else begin
            cur_idx = oldest_reg;
        end
        inc_ext = CW'(cur_idx) + CW'(1);
        if (inc_ext >= eff_quota) begin
            oldest_next = '0;
        end else begin
            oldest_next = inc_ext[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oldest_reg <= '0;
        end else if (advance) begin
            oldest_reg <= oldest_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/swrl_time_calc.sv */
// ---------------------------------------------------------------------------
// swrl_time_calc
// Permitted time: later of now and the saturated slot stamp plus window
// ---------------------------------------------------------------------------
`default_nettype none

module swrl_time_calc #(
    parameter int TIME_BITS = swrl_pkg::DEF_TIME_BITS
) (
    input  wire logic [TIME_BITS-1:0]          stamp,
    input  wire logic [swrl_pkg::WINDOW_W-1:0] window_length,
    input  wire logic [TIME_BITS-1:0]          now_time,
    output logic      [TIME_BITS-1:0]          permitted_time
);

    localparam int SUM_W = ((TIME_BITS > swrl_pkg::WINDOW_W) ?
                            TIME_BITS : swrl_pkg::WINDOW_W) + 1;

    logic [SUM_W-1:0]     sum;
    logic                 overflow;
    logic [TIME_BITS-1:0] cand;

    // saturating add
    assign sum      = SUM_W'(stamp) + SUM_W'(window_length);
    assign overflow = |sum[SUM_W-1:TIME_BITS];
    assign cand     = overflow ? '1 : sum[TIME_BITS-1:0];

    // later of the two
    assign permitted_time = (now_time > cand) ? now_time : cand;

endmodule

`default_nettype wire
